// ===== src/matrix3_inverse_assert.svh =====
// Assertion macros for the 3x3 matrix inverse block.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef MATRIX3_INVERSE_ASSERT_SVH
`define MATRIX3_INVERSE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define M3I_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the following clock edge.
`define M3I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/m3i_pkg.sv =====
// Shared types and constants for the 3x3 matrix inverse block.
// No dependencies; imported by every module of the block.
package m3i_pkg;

    // Entry and result formats
    localparam int EW   = 16;          // entry width, Q4.12
    localparam int EF   = 12;          // entry fraction bits
    localparam int OW   = 32;          // result width, Q16.16
    localparam int OF   = OW / 2;      // result fraction bits
    localparam int NE   = 9;           // entries per matrix
    localparam int PW   = 2 * EW;      // entry product width
    localparam int CW   = PW + 1;      // cofactor width
    localparam int DPW  = EW + CW;     // determinant term width
    localparam int DW   = 50;          // determinant width

    // Divider geometry: quotient = |cof| * 2^SH / |det|
    localparam int SH   = OF + EF;
    localparam int QW   = OW + 1;      // quotient bits produced
    localparam int NLO  = QW - SH;     // numerator bits fed during division

    // Queue and pipeline depths
    localparam int QDEPTH    = 8;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int FRONT_LAT = 4;
    localparam int BLAT      = QW + 2;

    typedef logic [3:0] t_idx;
    typedef logic [NE-1:0][EW-1:0] t_mat;
    typedef logic [NE-1:0][CW-1:0] t_cofs;
    typedef logic [NE-1:0][OW-1:0] t_inv;

    // One classified item between front and back
    typedef struct packed {
        t_cofs            cof;
        logic [DW-1:0]    det;
        logic             singular;
    } t_item;

    // Queue status toward the top level
    typedef struct packed {
        logic empty;
        logic busy;
    } t_qstat;

    // Cofactor k = a[L1]*a[L2] - a[R1]*a[R2], entries numbered row-major
    localparam t_idx COF_IDX [NE][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

// ===== src/m3i_front.sv =====
// Front end: cofactors, determinant and singular classification.
// Four-stage multiply pipeline; depends on m3i_pkg.
module m3i_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  m3i_pkg::t_mat   i_a,
    output logic            o_valid,
    output m3i_pkg::t_item  o_item
);
    import m3i_pkg::*;

    logic [FRONT_LAT-1:0]        r_v;
    logic signed [PW-1:0]        r_pl [NE];
    logic signed [PW-1:0]        r_pr [NE];
    logic signed [EW-1:0]        r_a1 [3];
    logic signed [EW-1:0]        r_a2 [3];
    logic signed [CW-1:0]        r_cof2 [NE];
    logic signed [CW-1:0]        r_cof3 [NE];
    logic signed [DPW-1:0]       r_dp [3];
    t_item                       r_item;
    logic signed [DW-1:0]        n_det;

    // Advance the valid marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[FRONT_LAT-2:0], i_valid};
        end
    end

    // Stage 1: entry products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NE; k++) begin
            r_pl[k] <= PW'($signed(i_a[COF_IDX[k][0]])) * PW'($signed(i_a[COF_IDX[k][1]]));
            r_pr[k] <= PW'($signed(i_a[COF_IDX[k][2]])) * PW'($signed(i_a[COF_IDX[k][3]]));
        end
        for (int j = 0; j < 3; j++) begin
            r_a1[j] <= $signed(i_a[j]);
        end
    end

    // Stage 2: cofactor differences
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NE; k++) begin
            r_cof2[k] <= CW'(r_pl[k]) - CW'(r_pr[k]);
        end
        for (int j = 0; j < 3; j++) begin
            r_a2[j] <= r_a1[j];
        end
    end

    // Stage 3: determinant terms along the first row
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r_dp[j] <= DPW'(r_a2[j]) * DPW'(r_cof2[3*j]);
        end
        for (int k = 0; k < NE; k++) begin
            r_cof3[k] <= r_cof2[k];
        end
    end

    // Stage 4: sum the terms and classify
    always_comb begin
        n_det = DW'(r_dp[0]) + DW'(r_dp[1]) + DW'(r_dp[2]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NE; k++) begin
            r_item.cof[k] <= r_cof3[k];
        end
        r_item.det      <= n_det;
        r_item.singular <= (n_det == '0);
    end

    assign o_valid = r_v[FRONT_LAT-1];
    assign o_item  = r_item;

endmodule

// ===== src/m3i_queue.sv =====
// Short FIFO that decouples the front end from the divider back end.
// Depends on m3i_pkg and the assertion macro header.
module m3i_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  m3i_pkg::t_item   i_item,
    input  logic             i_pop,
    output m3i_pkg::t_item   o_item,
    output m3i_pkg::t_qstat  o_stat
);
    import m3i_pkg::*;
    `include "matrix3_inverse_assert.svh"

    t_item          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;
    logic           pop_ok;

    assign pop_ok = i_pop && (r_count != '0);

    // Store pushed items
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QAW+1)'(i_push) - (QAW+1)'(pop_ok);
        end
    end

    assign o_item       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    // Hold off new transactions while the items in flight could overrun the queue
    assign o_stat.busy  = (r_count >= (QAW+1)'(QDEPTH - FRONT_LAT - 1));

    `M3I_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !pop_ok && r_count == (QAW+1)'(QDEPTH)), "queue overflow")
    `M3I_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !pop_ok, r_count == $past(r_count) + 1'b1, "queue count did not grow")
    `M3I_ASSERT_NEXT(a_count_down, i_clk, i_rst_n, pop_ok && !i_push, r_count == $past(r_count) - 1'b1, "queue count did not shrink")

endmodule

// ===== src/m3i_div_lane.sv =====
// One pipelined divider lane: rounded, saturated |cof| * 2^SH / |det| with sign.
// One restoring step per stage; depends on m3i_pkg.
module m3i_div_lane (
    input  logic                    i_clk,
    input  logic [m3i_pkg::CW-1:0]  i_cof,
    input  logic [m3i_pkg::DW-1:0]  i_det,
    output logic [m3i_pkg::OW-1:0]  o_val
);
    import m3i_pkg::*;

    localparam logic [QW:0] LIM = (QW+1)'(1) << (OW - 1);

    logic [DW-1:0]  r_rem [QW+1];
    logic [DW-1:0]  r_d   [QW+1];
    logic [QW-1:0]  r_q   [QW+1];
    logic [NLO-1:0] r_nlo [QW+1];
    logic           r_neg [QW+1];
    logic           r_ovf [QW+1];
    logic [OW-1:0]  r_out;

    logic [CW-1:0]  n_mag;
    logic [DW-1:0]  d_mag;

    // Take magnitudes and check for quotient overflow
    always_comb begin
        n_mag = i_cof[CW-1] ? (~i_cof + 1'b1) : i_cof;
        d_mag = i_det[DW-1] ? (~i_det + 1'b1) : i_det;
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= DW'(n_mag >> NLO);
        r_nlo[0] <= n_mag[NLO-1:0];
        r_d[0]   <= d_mag;
        r_q[0]   <= '0;
        r_neg[0] <= i_cof[CW-1] ^ i_det[DW-1];
        r_ovf[0] <= (DW'(n_mag >> NLO) >= d_mag);
    end

    // One quotient bit per stage, most significant first
    for (genvar i = 0; i < QW; i++) begin : g_step
        localparam int K = QW - 1 - i;
        logic          nb;
        logic [DW:0]   t;
        logic          ge;
        if (K >= SH) begin : g_bit
            assign nb = r_nlo[i][K-SH];
        end else begin : g_zero
            assign nb = 1'b0;
        end
        assign t  = {r_rem[i], nb};
        assign ge = (t >= {1'b0, r_d[i]});

        always_ff @(posedge i_clk) begin
            r_rem[i+1] <= ge ? DW'(t - {1'b0, r_d[i]}) : t[DW-1:0];
            r_q[i+1]   <= {r_q[i][QW-2:0], ge};
            r_d[i+1]   <= r_d[i];
            r_nlo[i+1] <= r_nlo[i];
            r_neg[i+1] <= r_neg[i];
            r_ovf[i+1] <= r_ovf[i];
        end
    end

    // Round half away from zero, saturate, apply sign
    logic          rnd;
    logic [QW:0]   qr;
    logic [QW:0]   mag;
    logic [QW:0]   sval;

    always_comb begin
        rnd = ({r_rem[QW], 1'b0} >= {1'b0, r_d[QW]});
        qr  = {1'b0, r_q[QW]} + (QW+1)'(rnd);
        if (r_neg[QW]) begin
            mag  = (r_ovf[QW] || qr > LIM) ? LIM : qr;
            sval = ~mag + 1'b1;
        end else begin
            mag  = (r_ovf[QW] || qr > LIM - 1'b1) ? (LIM - 1'b1) : qr;
            sval = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= sval[OW-1:0];
    end

    assign o_val = r_out;

endmodule

// ===== src/m3i_back.sv =====
// Back end: nine divider lanes plus the determinant and flag delay line.
// Depends on m3i_pkg and m3i_div_lane.
module m3i_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  m3i_pkg::t_item         i_item,
    output logic                   o_valid,
    output m3i_pkg::t_inv          o_inv,
    output logic [m3i_pkg::DW-1:0] o_det,
    output logic                   o_singular
);
    import m3i_pkg::*;

    logic [BLAT-1:0] r_v;
    logic [BLAT-1:0] r_sing;
    logic [DW-1:0]   r_det [BLAT];
    t_inv            lane_out;

    // Nine lanes share the determinant
    for (genvar k = 0; k < NE; k++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk (i_clk),
            .i_cof (i_item.cof[k]),
            .i_det (i_item.det),
            .o_val (lane_out[k])
        );
    end

    // Advance valid markers alongside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[BLAT-2:0], i_valid};
        end
    end

    // Delay determinant and singular flag to match the lanes
    always_ff @(posedge i_clk) begin
        r_sing <= {r_sing[BLAT-2:0], i_item.singular};
        r_det[0] <= i_item.det;
        for (int s = 1; s < BLAT; s++) begin
            r_det[s] <= r_det[s-1];
        end
    end

    // Drop the lane results for a singular matrix
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            o_inv[k] = r_sing[BLAT-1] ? '0 : lane_out[k];
        end
    end

    assign o_valid    = r_v[BLAT-1];
    assign o_det      = r_det[BLAT-1];
    assign o_singular = r_sing[BLAT-1];

endmodule

// ===== src/matrix3_inverse.sv =====
// Top level of the 3x3 matrix inverse: front end, queue and divider back end.
// Depends on m3i_pkg, m3i_front, m3i_queue and m3i_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | start, busy          | i_a00 .. i_a22 (signed Q4.12)
//  result   | o_done (one cycle)   | o_b00 .. o_b22, o_determinant, o_singular
//
// One matrix is taken per cycle while busy is low; each result passes through
// the 4 front multiply stages, the queue and the 35 divider stages (one
// restoring step per quotient bit plus entry and rounding). Synchronous
// active-low reset clears the valid markers and the queue. The receiver
// cannot stall; busy rises once the queue holds three items.
module matrix3_inverse (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_a00,
    input  logic [15:0] i_a01,
    input  logic [15:0] i_a02,
    input  logic [15:0] i_a10,
    input  logic [15:0] i_a11,
    input  logic [15:0] i_a12,
    input  logic [15:0] i_a20,
    input  logic [15:0] i_a21,
    input  logic [15:0] i_a22,
    output logic        o_done,
    output logic [31:0] o_b00,
    output logic [31:0] o_b01,
    output logic [31:0] o_b02,
    output logic [31:0] o_b10,
    output logic [31:0] o_b11,
    output logic [31:0] o_b12,
    output logic [31:0] o_b20,
    output logic [31:0] o_b21,
    output logic [31:0] o_b22,
    output logic [49:0] o_determinant,
    output logic        o_singular
);
    import m3i_pkg::*;

    t_mat    mat;
    logic    front_valid;
    t_item   front_item;
    t_item   q_item;
    t_qstat  q_stat;
    t_inv    inv;
    logic    accept;

    assign mat    = {i_a22, i_a21, i_a20, i_a12, i_a11, i_a10, i_a02, i_a01, i_a00};
    assign accept = start && !busy;
    assign busy   = q_stat.busy;

    // Classify each transaction
    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_a     (mat),
        .o_valid (front_valid),
        .o_item  (front_item)
    );

    // Buffer classified items
    m3i_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .i_pop   (1'b1),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    // Divide and deliver
    m3i_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!q_stat.empty),
        .i_item     (q_item),
        .o_valid    (o_done),
        .o_inv      (inv),
        .o_det      (o_determinant),
        .o_singular (o_singular)
    );

    assign o_b00 = inv[0];
    assign o_b01 = inv[1];
    assign o_b02 = inv[2];
    assign o_b10 = inv[3];
    assign o_b11 = inv[4];
    assign o_b12 = inv[5];
    assign o_b20 = inv[6];
    assign o_b21 = inv[7];
    assign o_b22 = inv[8];

endmodule
